// ===== design/rpn_pkg.sv =====
// shared types and constants for the rpn stack calculator
package rpn_pkg;

    localparam int NumVars  = 26;
    localparam int VarBits  = 5;
    localparam int ValBits  = 32;

    typedef logic [3:0] t_action;
    typedef logic [2:0] t_status;

    localparam t_action ACT_PUSH   = 4'd0;
    localparam t_action ACT_RECALL = 4'd1;
    localparam t_action ACT_ADD    = 4'd2;
    localparam t_action ACT_MUL    = 4'd3;
    localparam t_action ACT_SUB    = 4'd4;
    localparam t_action ACT_DIV    = 4'd5;
    localparam t_action ACT_MOD    = 4'd6;
    localparam t_action ACT_ASSIGN = 4'd7;
    localparam t_action ACT_PEEK   = 4'd8;
    localparam t_action ACT_DUP    = 4'd9;
    localparam t_action ACT_SWAP   = 4'd10;
    localparam t_action ACT_CLEAR  = 4'd11;
    localparam t_action ACT_SHOW   = 4'd12;

    localparam t_status ST_OK    = 3'd0;
    localparam t_status ST_EMPTY = 3'd1;
    localparam t_status ST_FULL  = 3'd2;
    localparam t_status ST_ZDIV  = 3'd3;
    localparam t_status ST_SWAP  = 3'd4;
    localparam t_status ST_NOVAR = 3'd5;

    localparam logic [VarBits-1:0] VAR_NONE = 5'd26;

    typedef struct packed {
        logic [3:0]  action;
        logic [31:0] number;
        logic [4:0]  var_index;
    } t_in_item;

    typedef struct packed {
        logic [31:0] shown_value;
        logic        shown;
        logic [2:0]  status;
        logic [7:0]  level;
    } t_out_item;

    // divider control
    typedef struct packed {
        logic        start;
        logic        is_mod;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } t_div_rsp;

endpackage

// ===== design/rpn_if.sv =====
// valid/ready channel interfaces for input and result items
interface rpn_in_if;
    import rpn_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rpn_out_if;
    import rpn_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/rpn_ram.sv =====
// generic single port ram with registered read
module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== design/rpn_div.sv =====
// iterative restoring divider for q16.16 division and integer modulo
module rpn_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rpn_pkg::t_div_req i_req,
    output rpn_pkg::t_div_rsp o_rsp
);
    import rpn_pkg::*;

    logic [47:0] r_quo, n_quo;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy, r_neg, r_mod, r_done;
    logic [32:0] trial;
    logic [31:0] rem_sh;
    logic [47:0] num_mag;
    logic [31:0] den_mag;
    logic [15:0] a_int, b_int;
    logic [63:0] q_s;
    logic [31:0] res;

    // operand setup: div uses |a|<<16 / |b|, mod uses integer parts
    always_comb begin
        a_int = i_req.dividend[31] ? 16'(-$signed(i_req.dividend) >>> 16)
                                   : i_req.dividend[31:16];
        b_int = i_req.divisor[31] ? 16'(-$signed(i_req.divisor) >>> 16)
                                  : i_req.divisor[31:16];
        if (i_req.is_mod) begin
            num_mag = {32'd0, a_int};
            den_mag = {16'd0, b_int};
        end else begin
            num_mag = {(i_req.dividend[31] ? 32'(-i_req.dividend)
                                           : i_req.dividend), 16'd0};
            den_mag = i_req.divisor[31] ? 32'(-i_req.divisor) : i_req.divisor;
        end
    end

    // one quotient bit per cycle
    always_comb begin
        rem_sh = {r_rem[30:0], r_quo[47]};
        trial  = {1'b0, rem_sh} - {1'b0, r_den};
        n_rem  = r_rem;
        n_quo  = r_quo;
        if (r_busy) begin
            n_quo = {r_quo[46:0], ~trial[32] | r_rem[31]};
            n_rem = (~trial[32] | r_rem[31]) ? trial[31:0] : rem_sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd48;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_req.start) begin
            r_quo <= num_mag;
            r_rem <= 32'd0;
            r_den <= den_mag;
            r_mod <= i_req.is_mod;
            r_neg <= i_req.is_mod ? i_req.dividend[31]
                                  : (i_req.dividend[31] ^ i_req.divisor[31]);
        end else begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    // sign the result, and saturate the division quotient
    always_comb begin
        if (r_mod) begin
            q_s = r_neg ? -{32'd0, r_rem} : {32'd0, r_rem};
            res = {q_s[15:0], 16'd0};
        end else begin
            q_s = r_neg ? -{16'd0, r_quo} : {16'd0, r_quo};
            if (!r_neg && r_quo > 48'h7FFFFFFF) begin
                res = 32'h7FFFFFFF;
            end else if (r_neg && r_quo > 48'h80000000) begin
                res = 32'h80000000;
            end else begin
                res = q_s[31:0];
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = res;
endmodule

// ===== design/rpn_stack_calculator_unit.sv =====
// top level of the rpn stack calculator: sequencer around stack and variable rams
// div and mod wait on the 48-step divider
// throughput: one item at a time; the next item is taken once the sequencer is back
// in its idle state, and a result still waiting holds the sequencer in its done state
// reset: i_rst_n synchronous active low clears level, defined flags, last variable
// and handshake state; the rams keep their contents
module rpn_stack_calculator_unit #(
    parameter int STACK_DEPTH = 128
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    rpn_in_if.sink   i_in,
    rpn_out_if.source o_out
);
    import rpn_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int LW = $clog2(STACK_DEPTH + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD1   = 4'd1;
    localparam logic [3:0] S_RD2   = 4'd2;
    localparam logic [3:0] S_EXEC  = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_DIVW  = 4'd5;
    localparam logic [3:0] S_WR1   = 4'd6;
    localparam logic [3:0] S_WR2   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;
    localparam logic [3:0] S_VRD   = 4'd9;
    localparam logic [3:0] S_RDA   = 4'd10;

    logic [3:0]  r_state;
    logic [LW-1:0] r_lvl;
    logic [NumVars-1:0] r_def;
    logic [VarBits-1:0] r_last;
    t_in_item    r_item;
    logic [31:0] r_a, r_b, r_w1, r_w2;
    logic        r_w2_en;
    logic [2:0]  r_st;
    logic [31:0] r_show;
    logic        r_shown;
    logic        r_ovalid;
    t_out_item   r_out;
    logic [63:0] r_prod;

    logic        s_we, v_we;
    logic [AW-1:0] s_addr;
    logic [31:0] s_wdata, s_rdata, v_rdata;
    logic [VarBits-1:0] v_addr;
    t_div_req    dreq;
    t_div_rsp    drsp;

    rpn_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(s_we), .i_addr(s_addr), .i_wdata(s_wdata), .o_rdata(s_rdata)
    );
    rpn_ram #(.WIDTH(32), .DEPTH(NumVars)) u_vars (
        .i_clk(i_clk), .i_we(v_we), .i_addr(v_addr), .i_wdata(r_w1), .o_rdata(v_rdata)
    );
    rpn_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(dreq), .o_rsp(drsp));

    logic accept;
    assign accept = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    // helpers
    logic [LW-1:0] depth_c;
    logic          full, is_bin;
    logic [32:0]   sum;
    logic [31:0]   addsub;
    logic [63:0]   pr_sh;
    logic [31:0]   mulv;
    logic [31:0]   b_int_chk;
    assign depth_c = LW'(STACK_DEPTH);
    assign full = r_lvl >= depth_c;
    assign is_bin = r_item.action == ACT_ADD || r_item.action == ACT_MUL ||
                    r_item.action == ACT_SUB;
    always_comb begin
        if (r_item.action == ACT_SUB) begin
            sum = {r_a[31], r_a} - {r_b[31], r_b};
        end else begin
            sum = {r_a[31], r_a} + {r_b[31], r_b};
        end
        if (sum[32] != sum[31]) begin
            addsub = sum[32] ? 32'h80000000 : 32'h7FFFFFFF;
        end else begin
            addsub = sum[31:0];
        end
        pr_sh = $signed(r_prod) >>> 16;
        if ($signed(pr_sh) > 64'sh7FFFFFFF) begin
            mulv = 32'h7FFFFFFF;
        end else if ($signed(pr_sh) < -64'sh80000000) begin
            mulv = 32'h80000000;
        end else begin
            mulv = pr_sh[31:0];
        end
        b_int_chk = r_b[31] ? 32'(-r_b) : r_b;
    end

    // ram addressing and divider start, no stack write once the stack is full
    always_comb begin
        s_we = 1'b0;
        s_addr = AW'(r_lvl - LW'(1));
        s_wdata = r_w1;
        v_we = 1'b0;
        v_addr = r_item.action == ACT_RECALL ? r_item.var_index : r_last;
        dreq = '0;
        case (r_state)
            S_RD2: s_addr = AW'(r_lvl - LW'(2));
            S_WR1: begin
                s_we = !full;
                s_addr = AW'(r_lvl);
                v_we = r_item.action == ACT_ASSIGN;
            end
            S_WR2: begin
                s_we = !full;
                s_addr = AW'(r_lvl);
                s_wdata = r_w2;
            end
            S_EXEC: begin
                dreq.start = r_item.action == ACT_DIV || r_item.action == ACT_MOD;
                dreq.is_mod = r_item.action == ACT_MOD;
                dreq.dividend = r_a;
                dreq.divisor = r_b;
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lvl <= '0;
            r_def <= '0;
            r_last <= VAR_NONE;
            r_ovalid <= 1'b0;
        end else begin
            if (o_out.valid && o_out.ready && r_state != S_DONE) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: if (accept) begin
                    r_item <= i_in.data;
                    r_st <= ST_OK;
                    r_shown <= 1'b0;
                    r_show <= '0;
                    r_w2_en <= 1'b0;
                    r_a <= '0;
                    r_b <= '0;
                    r_state <= S_RD1;
                end
                S_RD1: begin
                    // ram read of top issued this cycle
                    r_state <= S_RD2;
                    case (r_item.action)
                        ACT_PUSH: begin
                            r_w1 <= r_item.number;
                            r_state <= S_WR1;
                        end
                        ACT_RECALL: begin
                            if (r_item.var_index >= VarBits'(NumVars)) begin
                                r_st <= ST_NOVAR;
                                r_state <= S_DONE;
                            end else begin
                                r_last <= r_item.var_index;
                                r_state <= r_def[r_item.var_index] ? S_VRD : S_DONE;
                            end
                        end
                        ACT_ASSIGN: if (r_last >= VarBits'(NumVars)) begin
                            r_st <= ST_NOVAR;
                            r_state <= S_DONE;
                        end
                        ACT_SWAP: if (r_lvl < LW'(2)) begin
                            r_st <= ST_SWAP;
                            r_state <= S_DONE;
                        end
                        ACT_CLEAR: begin
                            r_lvl <= '0;
                            r_state <= S_DONE;
                        end
                        ACT_PEEK, ACT_DUP, ACT_SHOW, ACT_ADD, ACT_MUL, ACT_SUB,
                        ACT_DIV, ACT_MOD: ;
                        default: r_state <= S_DONE;
                    endcase
                end
                S_VRD: begin
                    r_w1 <= v_rdata;
                    r_state <= S_WR1;
                end
                S_RD2: begin
                    // s_rdata holds top, second read issued
                    if (r_lvl == '0) begin
                        r_b <= '0;
                    end else begin
                        r_b <= s_rdata;
                    end
                    r_state <= S_RDA;
                end
                S_RDA: begin
                    // s_rdata holds second entry; pops applied here
                    r_state <= S_EXEC;
                    case (r_item.action)
                        ACT_PEEK: begin
                            if (r_lvl == '0) r_st <= ST_EMPTY;
                            else begin
                                r_show <= r_b;
                                r_shown <= 1'b1;
                            end
                            r_state <= S_DONE;
                        end
                        ACT_SHOW: begin
                            if (r_lvl == '0) r_st <= ST_EMPTY;
                            else r_lvl <= r_lvl - LW'(1);
                            r_show <= r_b;
                            r_shown <= 1'b1;
                            r_state <= S_DONE;
                        end
                        ACT_DUP, ACT_ASSIGN: begin
                            if (r_lvl == '0) r_st <= ST_EMPTY;
                            else r_lvl <= r_lvl - LW'(1);
                            r_w1 <= r_b;
                            r_w2 <= r_b;
                            r_w2_en <= r_item.action == ACT_DUP;
                            r_state <= S_WR1;
                        end
                        ACT_SWAP: begin
                            r_lvl <= r_lvl - LW'(2);
                            r_w1 <= r_b;
                            r_w2 <= s_rdata;
                            r_w2_en <= 1'b1;
                            r_state <= S_WR1;
                        end
                        default: begin
                            // binary: pop b, then a unless div/mod by zero
                            if (r_lvl == '0) begin
                                r_st <= ST_EMPTY;
                            end else begin
                                r_lvl <= r_lvl - LW'(1);
                            end
                            if ((r_item.action == ACT_DIV && r_b == '0) ||
                                (r_item.action == ACT_MOD && b_int_chk[31:16] == '0)) begin
                                if (r_lvl == '0) r_st <= ST_EMPTY;
                                else r_st <= ST_ZDIV;
                                r_state <= S_DONE;
                            end else if (r_lvl < LW'(2)) begin
                                r_st <= ST_EMPTY;
                                r_a <= '0;
                                r_lvl <= '0;
                            end else begin
                                r_a <= s_rdata;
                                r_lvl <= r_lvl - LW'(2);
                            end
                        end
                    endcase
                end
                S_EXEC: begin
                    if (r_item.action == ACT_MUL) begin
                        r_prod <= 64'($signed(r_a) * $signed(r_b));
                        r_state <= S_MUL;
                    end else if (is_bin) begin
                        r_w1 <= addsub;
                        r_state <= S_WR1;
                    end else begin
                        r_state <= S_DIVW;
                    end
                end
                S_MUL: begin
                    r_w1 <= mulv;
                    r_state <= S_WR1;
                end
                S_DIVW: if (drsp.done) begin
                    r_w1 <= drsp.result;
                    r_state <= S_WR1;
                end
                S_WR1: begin
                    if (r_lvl < depth_c) begin
                        r_lvl <= r_lvl + LW'(1);
                    end else if (r_st == ST_OK) begin
                        r_st <= ST_FULL;
                    end
                    if (r_item.action == ACT_ASSIGN) r_def[r_last] <= 1'b1;
                    r_state <= r_w2_en ? S_WR2 : S_DONE;
                end
                S_WR2: begin
                    if (r_lvl < depth_c) begin
                        r_lvl <= r_lvl + LW'(1);
                    end else if (r_st == ST_OK) begin
                        r_st <= ST_FULL;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // hold here while the previous result item is still waiting
                    if (!r_ovalid || o_out.ready) begin
                        r_out.shown_value <= r_show;
                        r_out.shown <= r_shown;
                        r_out.status <= r_st;
                        r_out.level <= 8'(r_lvl);
                        r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_out;
endmodule

// ===== test/tb.sv =====
// testbench for the rpn stack calculator: directed table, random tokens, predictor check
module tb;
    import rpn_pkg::*;

    localparam int StackDepth = 128;
    localparam int NumRandom  = 1300;
    localparam int HoldStart  = 3000;
    localparam int HoldLen    = 400;
    localparam int CalmStart  = 8000;
    localparam int CalmEnd    = 14000;

    typedef struct {
        t_action     act;
        logic [31:0] num;
        logic [4:0]  vi;
        bit          typed;
        t_out_item   res;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    int   cyc;
    int   errors;

    rpn_in_if  in_ch ();
    rpn_out_if out_ch ();

    rpn_stack_calculator_unit #(.STACK_DEPTH(StackDepth)) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
    end

    // calculator state kept by the predictor
    logic signed [31:0] calc_stack [StackDepth];
    int                 calc_level;
    logic signed [31:0] calc_vars [NumVars];
    bit                 calc_def [NumVars];
    int                 calc_last;
    t_status            calc_st;

    t_out_item expected_results [$];
    bit        typed_flags [$];
    t_out_item typed_results [$];

    function automatic void flag_fault(t_status code);
        if (calc_st == ST_OK) calc_st = code;
    endfunction

    function automatic void stack_push(logic signed [31:0] v);
        if (calc_level < StackDepth) begin
            calc_stack[calc_level] = v;
            calc_level++;
        end else begin
            flag_fault(ST_FULL);
        end
    endfunction

    function automatic logic signed [31:0] stack_pop();
        if (calc_level > 0) begin
            calc_level--;
            return calc_stack[calc_level];
        end
        flag_fault(ST_EMPTY);
        return 32'sd0;
    endfunction

    function automatic logic signed [31:0] saturate(logic signed [63:0] v);
        if (v > 64'sh7fffffff) return 32'sh7fffffff;
        if (v < -64'sh80000000) return 32'sh80000000;
        return v[31:0];
    endfunction

    // one token through the calculator, giving its result item
    function automatic t_out_item calc_token(t_in_item it);
        t_out_item          r;
        logic signed [31:0] a, b, t;
        logic signed [63:0] p, ai, bi;
        r = '0;
        calc_st = ST_OK;
        case (it.action)
            ACT_PUSH: stack_push(it.number);
            ACT_RECALL: begin
                if (it.var_index >= NumVars) begin
                    flag_fault(ST_NOVAR);
                end else begin
                    calc_last = it.var_index;
                    if (calc_def[calc_last]) stack_push(calc_vars[calc_last]);
                end
            end
            ACT_ADD, ACT_SUB, ACT_MUL: begin
                b = stack_pop();
                a = stack_pop();
                if (it.action == ACT_ADD) p = 64'(a) + 64'(b);
                else if (it.action == ACT_SUB) p = 64'(a) - 64'(b);
                else p = (64'(a) * 64'(b)) >>> 16;
                stack_push(saturate(p));
            end
            ACT_DIV: begin
                b = stack_pop();
                if (b == 0) begin
                    flag_fault(ST_ZDIV);
                end else begin
                    a = stack_pop();
                    stack_push(saturate((64'(a) * 64'sd65536) / 64'(b)));
                end
            end
            ACT_MOD: begin
                b = stack_pop();
                bi = 64'(b) / 64'sd65536;
                if (bi == 0) begin
                    flag_fault(ST_ZDIV);
                end else begin
                    a = stack_pop();
                    ai = 64'(a) / 64'sd65536;
                    stack_push(saturate((ai % bi) * 64'sd65536));
                end
            end
            ACT_ASSIGN: begin
                if (calc_last >= NumVars) begin
                    flag_fault(ST_NOVAR);
                end else begin
                    t = stack_pop();
                    calc_vars[calc_last] = t;
                    calc_def[calc_last] = 1'b1;
                    stack_push(t);
                end
            end
            ACT_PEEK: begin
                if (calc_level > 0) begin
                    r.shown_value = calc_stack[calc_level-1];
                    r.shown = 1'b1;
                end else begin
                    flag_fault(ST_EMPTY);
                end
            end
            ACT_DUP: begin
                t = stack_pop();
                stack_push(t);
                stack_push(t);
            end
            ACT_SWAP: begin
                if (calc_level < 2) begin
                    flag_fault(ST_SWAP);
                end else begin
                    t = calc_stack[calc_level-1];
                    calc_stack[calc_level-1] = calc_stack[calc_level-2];
                    calc_stack[calc_level-2] = t;
                end
            end
            ACT_CLEAR: calc_level = 0;
            ACT_SHOW: begin
                r.shown_value = stack_pop();
                r.shown = 1'b1;
            end
            default: ;
        endcase
        r.status = calc_st;
        r.level = calc_level[7:0];
        return r;
    endfunction

    // prediction on every accepted input item
    always @(posedge i_clk) begin
        t_out_item pred;
        t_out_item typ;
        bit        use_typed;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            pred = calc_token(in_ch.data);
            use_typed = typed_flags.pop_front();
            typ = typed_results.pop_front();
            expected_results.push_back(use_typed ? typ : pred);
        end
    end

    // result check against the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (expected_results.size() == 0) begin
                $error("result item with nothing expected: %h", got);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (got.shown_value !== want.shown_value) begin
                    $error("shown_value expected %h actual %h", want.shown_value,
                           got.shown_value);
                    errors++;
                end
                if (got.shown !== want.shown) begin
                    $error("shown expected %0d actual %0d", want.shown, got.shown);
                    errors++;
                end
                if (got.status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, got.status);
                    errors++;
                end
                if (got.level !== want.level) begin
                    $error("level expected %0d actual %0d", want.level, got.level);
                    errors++;
                end
            end
        end
    end

    // receiver: random stalls, one long hold-off, one calm stretch
    always @(posedge i_clk) begin
        if (cyc >= HoldStart && cyc < HoldStart + HoldLen) out_ch.ready <= 1'b0;
        else if (cyc >= CalmStart && cyc < CalmEnd) out_ch.ready <= 1'b1;
        else out_ch.ready <= ($urandom_range(99) >= 18);
    end

    function automatic t_row row(t_action act, logic [31:0] num, logic [4:0] vi,
                                 bit typed, logic [31:0] sv, logic sh, t_status st,
                                 logic [7:0] lvl);
        t_row r;
        r.act = act;
        r.num = num;
        r.vi = vi;
        r.typed = typed;
        r.res = '{shown_value: sv, shown: sh, status: st, level: lvl};
        return r;
    endfunction

    function automatic logic [31:0] rand_number();
        case ($urandom_range(5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(20)) - 10) <<< 16;
            2: return 32'h7fffffff;
            3: return 32'h80000000;
            4: return 32'(0);
            default: return 32'($signed($urandom_range(2000)) - 1000) <<< 12;
        endcase
    endfunction

    // sender: waits for each item to be taken, idles at random between items
    task automatic send(t_in_item it, bit typed, t_out_item res);
        typed_flags.push_back(typed);
        typed_results.push_back(res);
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        if (!(cyc >= CalmStart && cyc < CalmEnd) && $urandom_range(99) < 18) begin
            in_ch.valid <= 1'b0;
            in_ch.data <= '0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
    endtask

    initial begin
        t_row     rows [$];
        t_in_item it;
        int       k;
        int       w;
        errors = 0;
        cyc = 0;
        calc_level = 0;
        calc_last = VAR_NONE;
        foreach (calc_def[j]) calc_def[j] = 1'b0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed tokens: empty stack faults, no variable, saturation, divide by zero
        rows.push_back(row(ACT_SHOW, 0, 0, 1, 0, 1, ST_EMPTY, 0));
        rows.push_back(row(ACT_PEEK, 0, 0, 1, 0, 0, ST_EMPTY, 0));
        rows.push_back(row(ACT_SWAP, 0, 0, 1, 0, 0, ST_SWAP, 0));
        rows.push_back(row(ACT_ASSIGN, 0, 0, 1, 0, 0, ST_NOVAR, 0));
        rows.push_back(row(ACT_RECALL, 0, 26, 1, 0, 0, ST_NOVAR, 0));
        rows.push_back(row(ACT_RECALL, 0, 31, 1, 0, 0, ST_NOVAR, 0));
        rows.push_back(row(ACT_RECALL, 0, 3, 1, 0, 0, ST_OK, 0));
        rows.push_back(row(ACT_ASSIGN, 0, 0, 1, 0, 0, ST_EMPTY, 1));
        rows.push_back(row(ACT_RECALL, 0, 3, 1, 0, 0, ST_OK, 2));
        rows.push_back(row(ACT_ADD, 0, 0, 0, 0, 0, ST_OK, 0));
        rows.push_back(row(ACT_CLEAR, 0, 0, 1, 0, 0, ST_OK, 0));
        rows.push_back(row(ACT_PUSH, 32'h7fffffff, 0, 1, 0, 0, ST_OK, 1));
        rows.push_back(row(ACT_PUSH, 32'h00000001, 0, 1, 0, 0, ST_OK, 2));
        rows.push_back(row(ACT_ADD, 0, 0, 1, 0, 0, ST_OK, 1));
        rows.push_back(row(ACT_PEEK, 0, 0, 1, 32'h7fffffff, 1, ST_OK, 1));
        rows.push_back(row(ACT_PUSH, 32'h80000000, 0, 1, 0, 0, ST_OK, 2));
        rows.push_back(row(ACT_SWAP, 0, 0, 1, 0, 0, ST_OK, 2));
        rows.push_back(row(ACT_SUB, 0, 0, 1, 0, 0, ST_OK, 1));
        rows.push_back(row(ACT_SHOW, 0, 0, 1, 32'h80000000, 1, ST_OK, 0));
        rows.push_back(row(ACT_PUSH, 32'h00050000, 0, 1, 0, 0, ST_OK, 1));
        rows.push_back(row(ACT_PUSH, 32'h00000000, 0, 1, 0, 0, ST_OK, 2));
        rows.push_back(row(ACT_DIV, 0, 0, 1, 0, 0, ST_ZDIV, 1));
        rows.push_back(row(ACT_PUSH, 32'h00008000, 0, 1, 0, 0, ST_OK, 2));
        rows.push_back(row(ACT_MOD, 0, 0, 1, 0, 0, ST_ZDIV, 1));
        rows.push_back(row(ACT_PUSH, 32'hfff90000, 0, 0, 0, 0, ST_OK, 0));
        rows.push_back(row(ACT_PUSH, 32'h00020000, 0, 0, 0, 0, ST_OK, 0));
        rows.push_back(row(ACT_MOD, 0, 0, 0, 0, 0, ST_OK, 0));
        rows.push_back(row(ACT_DUP, 0, 0, 0, 0, 0, ST_OK, 0));
        rows.push_back(row(ACT_MUL, 0, 0, 0, 0, 0, ST_OK, 0));
        rows.push_back(row(ACT_DIV, 0, 0, 1, 0, 0, ST_OK, 1));
        rows.push_back(row(t_action'(13), 0, 0, 1, 0, 0, ST_OK, 1));
        rows.push_back(row(t_action'(15), 0, 0, 1, 0, 0, ST_OK, 1));
        foreach (rows[j]) begin
            it.action = rows[j].act;
            it.number = rows[j].num;
            it.var_index = rows[j].vi;
            send(it, rows[j].typed, rows[j].res);
        end

        // random tokens, arithmetic the largest share, on a shallow stack with bursts to full
        for (k = 0; k < NumRandom; k++) begin
            if (k % 500 == 250) begin
                repeat (StackDepth + 4) begin
                    it.action = ACT_PUSH;
                    it.number = rand_number();
                    it.var_index = 5'($urandom_range(31));
                    send(it, 0, '0);
                end
            end
            w = $urandom_range(99);
            if (w < 25) it.action = ACT_PUSH;
            else if (w < 32) it.action = ACT_RECALL;
            else if (w < 40) it.action = ACT_ADD;
            else if (w < 48) it.action = ACT_MUL;
            else if (w < 55) it.action = ACT_SUB;
            else if (w < 62) it.action = ACT_DIV;
            else if (w < 69) it.action = ACT_MOD;
            else if (w < 75) it.action = ACT_ASSIGN;
            else if (w < 80) it.action = ACT_PEEK;
            else if (w < 85) it.action = ACT_DUP;
            else if (w < 90) it.action = ACT_SWAP;
            else if (w < 92) it.action = ACT_CLEAR;
            else if (w < 98) it.action = ACT_SHOW;
            else it.action = t_action'($urandom_range(15, 13));
            it.number = rand_number();
            it.var_index = ($urandom_range(9) == 0) ? 5'($urandom_range(31))
                                                    : 5'($urandom_range(25));
            send(it, 0, '0);
        end
        in_ch.valid <= 1'b0;
        in_ch.data <= '0;

        // drain and let the divider settle
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // timeout
    initial begin
        #30000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
